@@ sv/pip_pkg.sv @@
// Shared constants and command codes for the point-in-polygon test unit.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam int CMD_W = 2;
  localparam int QDEPTH = 2;

endpackage

@@ sv/pip_front.sv @@
// Front end: two-entry command queue toward the execution engine.
module pip_front #(
  parameter int CW = pip_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic signed [CW-1:0]    in_coord_x,
  input  logic signed [CW-1:0]    in_coord_y,
  output logic                    q_valid,
  input  logic                    q_pop,
  output logic [1:0]              q_cmd,
  output logic signed [CW-1:0]    q_x,
  output logic signed [CW-1:0]    q_y
);
  import pip_pkg::*;

  localparam int EW = CMD_W + 2 * CW;

  logic [EW-1:0] mem_r [QDEPTH];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push;

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign {q_cmd, q_x, q_y} = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {in_cmd, in_coord_x, in_coord_y};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ sv/pip_edge.sv @@
// Edge evaluator: test of one polygon edge against the query point; products registered, compares combinational.
module pip_edge #(
  parameter int CW = pip_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by,
  output logic                 on_edge,
  output logic                 crossing
);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] lx, ly, tx, ty, dxi;
  logic signed [PW-1:0] m_lxtx_r, m_lyty_r, m_lxty_r, m_lytx_r;
  logic signed [PW-1:0] m_lxlx_r, m_lyly_r, m_txtx_r, m_tyty_r;
  logic signed [PW-1:0] m_lhs_r, m_rhs_r;
  logic                 straddle_r, dpos_r;
  logic signed [SW-1:0] dotp, crs;
  logic        [SW-1:0] nl, nt;

  // edge vector from a (vi) to b (vj); query offset from a
  assign lx  = DW'(px) - DW'(ax);
  assign ly  = DW'(py) - DW'(ay);
  assign tx  = DW'(bx) - DW'(ax);
  assign ty  = DW'(by) - DW'(ay);
  assign dxi = lx;

  always_ff @(posedge clk) begin
    m_lxtx_r   <= lx * tx;
    m_lyty_r   <= ly * ty;
    m_lxty_r   <= lx * ty;
    m_lytx_r   <= ly * tx;
    m_lxlx_r   <= lx * lx;
    m_lyly_r   <= ly * ly;
    m_txtx_r   <= tx * tx;
    m_tyty_r   <= ty * ty;
    m_lhs_r    <= dxi * ty;
    m_rhs_r    <= tx * ly;
    straddle_r <= (ay > py) != (by > py);
    dpos_r     <= (ty > 0);
  end

  assign dotp = SW'(m_lxtx_r) + SW'(m_lyty_r);
  assign crs  = SW'(m_lxty_r) - SW'(m_lytx_r);
  assign nl   = SW'(m_lxlx_r) + SW'(m_lyly_r);
  assign nt   = SW'(m_txtx_r) + SW'(m_tyty_r);

  assign on_edge  = (dotp >= 0) && (crs == 0) && (nl < nt);
  assign crossing = straddle_r &&
                    (dpos_r ? (m_lhs_r < m_rhs_r) : (m_lhs_r > m_rhs_r));

endmodule

@@ sv/pip_back.sv @@
// Back end: vertex store, edge walk sequencer and result register.
module pip_back #(
  parameter int MAXV = pip_pkg::MAX_VERTICES_DEF,
  parameter int CW   = pip_pkg::COORD_BITS_DEF,
  parameter int NW   = $clog2(MAXV + 1),
  parameter int AW   = (MAXV > 1) ? $clog2(MAXV) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 boundary_mode,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic [1:0]           q_cmd,
  input  logic signed [CW-1:0] q_x,
  input  logic signed [CW-1:0] q_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_inside_res,
  output logic                 out_status,
  output logic [NW-1:0]        out_vertex_count
);
  import pip_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic signed [CW-1:0] vx_mem [MAXV];
  logic signed [CW-1:0] vy_mem [MAXV];

  logic [2:0]           state_r;
  logic [NW-1:0]        count_r;
  logic [NW-1:0]        idx_r;     // store address read this cycle during the walk
  logic [NW-1:0]        ecnt_r;    // edges still to evaluate
  logic signed [CW-1:0] px_r, py_r;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, prevx_r, prevy_r;
  logic                 rd_v_r, ev_v_r, ev2_r;
  logic                 par_r, hit_r;
  logic                 closed_r, mode_small_r;
  logic                 busy_r;
  logic                 on_edge, crossing;
  logic                 ov_r, oins_r, ost_r;
  logic [NW-1:0]        ocnt_r;
  logic signed [CW-1:0] rdx_r, rdy_r;
  logic                 first_r;
  logic                 can_take;
  logic                 go_walk;
  logic                 ov_set;
  logic [NW-1:0]        rd_addr;

  assign out_valid        = ov_r;
  assign out_inside_res   = oins_r;
  assign out_status       = ost_r;
  assign out_vertex_count = ocnt_r;

  assign can_take = (state_r == ST_IDLE) && q_valid && (!ov_r || !out_stall);
  assign q_pop    = can_take;
  // queries that need the edge walk; the rest answer at once
  assign go_walk  = (q_cmd == CMD_QUERY) &&
                    !(count_r == '0 || (boundary_mode && count_r < NW'(3)));
  assign ov_set   = (can_take && !go_walk) ||
                    ((state_r == ST_DONE) && (!ov_r || !out_stall));
  // idle: fetch v[n-1] ahead of the walk
  assign rd_addr  = (state_r == ST_IDLE) ? count_r - NW'(1) : idx_r;

  pip_edge #(.CW(CW)) u_edge (
    .clk, .px(px_r), .py(py_r), .ax(ax_r), .ay(ay_r), .bx(bx_r), .by(by_r),
    .on_edge, .crossing
  );

  // vertex store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (can_take && q_cmd == CMD_APPEND && count_r < NW'(MAXV)) begin
      vx_mem[count_r[AW-1:0]] <= q_x;
      vy_mem[count_r[AW-1:0]] <= q_y;
    end
    rdx_r <= vx_mem[rd_addr[AW-1:0]];
    rdy_r <= vy_mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      rd_v_r  <= 1'b0;
      ev_v_r  <= 1'b0;
      ev2_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      ov_r  <= ov_set || (ov_r && out_stall);
      // ev2_r marks an edge result as ready; it follows ev_v_r, set as the edge's vertices load
      ev2_r <= ev_v_r;
      unique case (state_r)
        ST_IDLE: begin
          if (can_take) begin
            unique case (q_cmd)
              CMD_CLEAR: begin
                count_r <= '0;
                oins_r <= 1'b0; ost_r <= 1'b0; ocnt_r <= '0;
              end
              CMD_APPEND: begin
                oins_r <= 1'b0;
                if (count_r < NW'(MAXV)) begin
                  count_r <= count_r + NW'(1);
                  ocnt_r  <= count_r + NW'(1);
                  ost_r   <= 1'b0;
                end else begin
                  ocnt_r <= count_r;
                  ost_r  <= 1'b1;
                end
              end
              CMD_QUERY: begin
                if (!go_walk) begin
                  oins_r <= 1'b0; ost_r <= 1'b0; ocnt_r <= count_r;
                end else begin
                  px_r         <= q_x;
                  py_r         <= q_y;
                  closed_r     <= !boundary_mode;
                  mode_small_r <= (count_r < NW'(3));
                  par_r        <= 1'b0;
                  hit_r        <= 1'b0;
                  idx_r        <= '0;
                  ecnt_r       <= count_r;
                  first_r      <= 1'b1;
                  rd_v_r       <= 1'b1;
                  busy_r       <= 1'b1;
                  state_r      <= ST_WALK;
                end
              end
              default: begin
                oins_r <= 1'b0; ost_r <= 1'b0; ocnt_r <= count_r;
              end
            endcase
          end
        end
        ST_WALK: begin
          // read order: v[n-1], v[0], v[1], ... v[n-1]; edge pairs (v[i], v[prev])
          if (rd_v_r) begin
            if (first_r) begin
              prevx_r <= rdx_r; prevy_r <= rdy_r;
              first_r <= 1'b0;
              idx_r   <= idx_r + NW'(1);
            end else if (!busy_r) begin
              rd_v_r <= 1'b0;
            end
          end
          if (rd_v_r && !first_r && busy_r) begin
            ax_r <= rdx_r; ay_r <= rdy_r;
            bx_r <= prevx_r; by_r <= prevy_r;
            prevx_r <= rdx_r; prevy_r <= rdy_r;
            ev_v_r <= 1'b1;
            ecnt_r <= ecnt_r - NW'(1);
            idx_r  <= idx_r + NW'(1);
            if (ecnt_r == NW'(1) || mode_small_r) begin
              busy_r <= 1'b0;
              rd_v_r <= 1'b0;
            end
          end else begin
            ev_v_r <= 1'b0;
          end
          if (ev2_r) begin
            if (on_edge) begin
              hit_r <= 1'b1;
            end else if (crossing) begin
              par_r <= ~par_r;
            end
          end
          if (!rd_v_r && !ev_v_r && !first_r) begin
            state_r <= ST_LAST;
          end
        end
        ST_LAST: begin
          if (ev2_r) begin
            if (on_edge) begin
              hit_r <= 1'b1;
            end else if (crossing) begin
              par_r <= ~par_r;
            end
          end
          ev_v_r  <= 1'b0;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!ov_r || !out_stall) begin
            ost_r   <= 1'b0;
            ocnt_r  <= count_r;
            state_r <= ST_IDLE;
            if (mode_small_r) begin
              // one vertex: equality with v0; two vertices: segment v0 -> v1
              if (count_r == NW'(1)) begin
                oins_r <= (px_r == ax_r) && (py_r == ay_r);
              end else begin
                oins_r <= hit_r;
              end
            end else begin
              oins_r <= hit_r ? closed_r : par_r;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/point_in_polygon_test_unit.sv @@
// Top level of the point-in-polygon test unit.
// Usage:
//  - in_ channel carries a word {cmd, coord_x, coord_y}; accepted when in_valid
//    is high and in_stall is low. cmd: clear, append vertex, query point, none.
//  - out_ channel returns one word per input word, in order: inside_res,
//    status (append dropped, store full) and vertex_count after the word.
//  - cfg_ channel writes boundary_mode (0 closed, 1 open) when cfg_valid and
//    cfg_ready are high; write only while the unit is idle.
// Flow:
//  - A two-entry queue decouples the input from the edge engine.
//  - Clear and append: the result is registered in the cycle after the engine
//    pops the word; between input accept and pop the word waits in a queue
//    entry. One word per cycle when the output flows.
//  - A query walks one edge per cycle through the edge evaluator; the next
//    word is taken once the engine is back in idle after the result loads.
//    The one-edge-per-cycle walk sets the rate.
// Reset (rst_n low, synchronous): vertex count and boundary_mode clear, queue
//  empties; vertex store contents are undefined until written.
// A stalled output holds its word; the engine waits and the queue fills,
//  after which in_stall rises.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
  parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_boundary_mode,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  output logic                         out_status,
  output logic [NW-1:0]                out_vertex_count
);
  import pip_pkg::*;

  logic                         mode_r;
  logic                         q_valid, q_pop;
  logic [1:0]                   q_cmd;
  logic signed [COORD_BITS-1:0] q_x, q_y;

  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_boundary_mode;
    end
  end

  pip_front #(.CW(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_coord_x, .in_coord_y,
    .q_valid, .q_pop, .q_cmd, .q_x, .q_y
  );

  pip_back #(.MAXV(MAX_VERTICES), .CW(COORD_BITS), .NW(NW)) u_back (
    .clk, .rst_n, .boundary_mode(mode_r), .q_valid, .q_pop, .q_cmd, .q_x, .q_y,
    .out_valid, .out_stall, .out_inside_res, .out_status, .out_vertex_count
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vertex_count <= NW'(MAX_VERTICES))
    else $error("vertex count out of range");
  a_status_only_append: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_vertex_count == NW'(MAX_VERTICES)))
    else $error("drop flagged below full store");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_status && out_inside_res))
    else $error("inside and drop flags together");
`endif

endmodule

@@ dv/point_in_polygon_test_unit_tb.sv @@
// Self-checking testbench for the point-in-polygon test unit.
module point_in_polygon_test_unit_tb;
  import pip_pkg::*;

  localparam int MAXV = MAX_VERTICES_DEF;
  localparam int CB   = COORD_BITS_DEF;
  localparam int NW   = $clog2(MAXV + 1);

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
  } cmd_word_t;

  typedef struct packed {
    logic          ins;
    logic          status;
    logic [NW-1:0] count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_boundary_mode = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_CLEAR;
  logic signed [CB-1:0] in_coord_x = '0;
  logic signed [CB-1:0] in_coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_inside_res;
  logic out_status;
  logic [NW-1:0] out_vertex_count;

  point_in_polygon_test_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_boundary_mode(cfg_boundary_mode),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_inside_res(out_inside_res),
    .out_status(out_status), .out_vertex_count(out_vertex_count)
  );

  always #5 clk = ~clk;

  // Predictor state: a mirror of the vertex store and mode register.
  longint poly_x [MAXV];
  longint poly_y [MAXV];
  int     poly_n = 0;
  bit     open_mode = 1'b0;

  cmd_word_t pending_words[$];
  answer_t   expected_answers[$];
  int        mismatches = 0;
  int        queued = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  task automatic add_word(input cmd_word_t w);
    pending_words = {pending_words, w};
    queued++;
  endtask

  // Half-open edge a->b: contains a, excludes b, degenerate edge empty.
  function automatic bit point_on_edge(longint px, longint py, longint ax, longint ay,
                                       longint bx, longint by);
    longint lx, ly, tx, ty;
    lx = px - ax; ly = py - ay; tx = bx - ax; ty = by - ay;
    return (lx * tx + ly * ty >= 0) && (lx * ty - ly * tx == 0) &&
           (lx * lx + ly * ly < tx * tx + ty * ty);
  endfunction

  function automatic bit point_inside(longint px, longint py);
    bit parity;
    int j;
    longint d, lhs, rhs;
    parity = 1'b0;
    if (!open_mode) begin
      if (poly_n == 0) return 1'b0;
      if (poly_n == 1) return px == poly_x[0] && py == poly_y[0];
      if (poly_n == 2) return point_on_edge(px, py, poly_x[0], poly_y[0], poly_x[1], poly_y[1]);
    end else if (poly_n < 3) begin
      return 1'b0;
    end
    j = poly_n - 1;
    for (int i = 0; i < poly_n; i++) begin
      if (point_on_edge(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
        return !open_mode;
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        d = poly_y[j] - poly_y[i];
        lhs = (px - poly_x[i]) * d;
        rhs = (poly_x[j] - poly_x[i]) * (py - poly_y[i]);
        if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) parity = !parity;
      end
      j = i;
    end
    return parity;
  endfunction

  // Advance the predictor by one accepted word and queue its answer.
  task automatic predict_word(input cmd_word_t w);
    answer_t a;
    a = '0;
    case (w.cmd)
      CMD_CLEAR: poly_n = 0;
      CMD_APPEND: begin
        if (poly_n < MAXV) begin
          poly_x[poly_n] = w.x;
          poly_y[poly_n] = w.y;
          poly_n++;
        end else begin
          a.status = 1'b1;
        end
      end
      CMD_QUERY: a.ins = point_inside(w.x, w.y);
      default: ;
    endcase
    a.count = NW'(poly_n);
    expected_answers = {expected_answers, a};
  endtask

  // Driver: bursts of words with random gaps; payload held while stalled.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_word({in_cmd, in_coord_x, in_coord_y});
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          cmd_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_cmd <= w.cmd;
          in_coord_x <= w.x;
          in_coord_y <= w.y;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stalls in runs, with stall-free stretches.
  int stall_phase = 0;
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_inside_res, out_status, out_vertex_count};
        if (expected_answers.size() == 0) begin
          report("unexpected word", int'(got), 0);
        end else begin
          want = expected_answers.pop_front();
          if (got.ins !== want.ins) report("inside_res", int'(got.ins), int'(want.ins));
          if (got.status !== want.status)
            report("status", int'(got.status), int'(want.status));
          if (got.count !== want.count)
            report("vertex_count", int'(got.count), int'(want.count));
        end
      end
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 150) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  function automatic cmd_word_t mk(input logic [1:0] c, input int x, input int y);
    cmd_word_t w;
    w.cmd = c;
    w.x = CB'(x);
    w.y = CB'(y);
    return w;
  endfunction

  function automatic logic signed [CB-1:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return CB'($urandom);                             // full range
      1: return CB'(int'($urandom_range(0, 40)) - 20);     // tight cluster, exact hits
      2: return CB'(($urandom_range(0, 1) ? 32767 : -32768) +
                    (($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 2))));
      default: return CB'((int'($urandom_range(0, 16)) - 8) * 16);
    endcase
  endfunction

  // Random polygon with queries, plus noise words.
  task automatic queue_random_set();
    int nv, nq;
    cmd_word_t v0, v1;
    v0 = '0;
    v1 = '0;
    add_word(mk(CMD_CLEAR, $urandom, $urandom));
    nv = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
    for (int k = 0; k < nv; k++) begin
      v1 = mk(CMD_APPEND, rnd_coord(), rnd_coord());
      if (k == 0) v0 = v1;
      add_word(v1);
    end
    nq = $urandom_range(2, 8);
    for (int k = 0; k < nq; k++) begin
      case ($urandom_range(0, 5))
        0: add_word(mk(CMD_QUERY, v0.x, v0.y));
        1: add_word(mk(CMD_QUERY, v1.x, v1.y));
        // midpoint of the closing edge: a boundary hit when exact
        2: add_word(mk(CMD_QUERY, (int'(v0.x) + int'(v1.x)) / 2,
                       (int'(v0.y) + int'(v1.y)) / 2));
        3: add_word(mk(CMD_NONE, $urandom, $urandom));
        default: add_word(mk(CMD_QUERY, rnd_coord(), rnd_coord()));
      endcase
    end
  endtask

  task automatic wait_drained();
    wait (pending_words.size() == 0 && !in_valid && expected_answers.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_boundary_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    open_mode = m;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: degenerate store sizes, a large quadrilateral, boundary and corners.
    for (int m = 0; m < 2; m++) begin
      write_mode(1'(m));
      add_word(mk(CMD_CLEAR, 0, 0));
      add_word(mk(CMD_QUERY, 0, 0));                // empty store
      add_word(mk(CMD_APPEND, 16, 16));
      add_word(mk(CMD_QUERY, 16, 16));              // single vertex
      add_word(mk(CMD_APPEND, 48, 16));
      add_word(mk(CMD_QUERY, 32, 16));              // on segment
      add_word(mk(CMD_QUERY, 48, 16));              // far end excluded
      add_word(mk(CMD_APPEND, 32767, 32767));
      add_word(mk(CMD_APPEND, -32768, 32767));
      add_word(mk(CMD_QUERY, 0, 1000));             // interior
      add_word(mk(CMD_QUERY, 32, 16));              // boundary
      add_word(mk(CMD_QUERY, -32768, -32768));      // outside corner
      add_word(mk(CMD_NONE, -1, -1));
      wait_drained();
    end
    // Fill past capacity to reach the dropped-append case.
    add_word(mk(CMD_CLEAR, 0, 0));
    for (int k = 0; k < MAXV + 2; k++)
      add_word(mk(CMD_APPEND, k * 7, (k % 2) ? -k : k));
    add_word(mk(CMD_QUERY, 5, 0));
    wait_drained();
    // Random phases, alternating the boundary mode.
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(1'(ph % 2));
      while (queued < (ph + 1) * 125) begin
        queue_random_set();
        wait (pending_words.size() < 20);
      end
      wait_drained();
    end
    if (mismatches == 0) $display("point_in_polygon_test_unit test passed");
    else $display("point_in_polygon_test_unit test failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("point_in_polygon_test_unit test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pip_pkg.sv
sv/pip_front.sv
sv/pip_edge.sv
sv/pip_back.sv
sv/point_in_polygon_test_unit.sv
dv/point_in_polygon_test_unit_tb.sv
